FILE: rtl/core/qau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg: shared types, codes and helpers of the quaternion arithmetic unit
// Holds the transaction structs, the operation and state codes, the
// saturation helpers and the micro-op table of the shared multiplier.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int ACC_W     = 52;
  localparam int NUM_W     = 34;
  localparam int DIV_DW    = NUM_W + FRAC_BITS;

  // Function codes as they arrive on the input port.
  localparam logic [3:0] FN_ADD    = 4'd0;
  localparam logic [3:0] FN_SUB    = 4'd1;
  localparam logic [3:0] FN_PROD   = 4'd2;
  localparam logic [3:0] FN_DIV    = 4'd3;
  localparam logic [3:0] FN_CONJ   = 4'd4;
  localparam logic [3:0] FN_NORM   = 4'd5;
  localparam logic [3:0] FN_NRMZ   = 4'd6;
  localparam logic [3:0] FN_INV    = 4'd7;
  localparam logic [3:0] FN_ROT    = 4'd8;
  localparam logic [3:0] FN_MAT    = 4'd9;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_PROD, OP_DIV, OP_CONJ, OP_NORM,
    OP_NRMZ, OP_INV, OP_ROT, OP_MAT, OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SQRT, S_DIV, S_FIN, S_ROW3
  } state_t;

  typedef enum logic [2:0] {
    PR_HAM, PR_SQ, PR_ROW0, PR_ROW1, PR_ROW2
  } prog_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] a_w;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
    logic [31:0] b_w;
  } qau_in_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] r_w;
    logic [1:0]  status;
    logic        last;
  } qau_out_t;

  // Classified transaction; index 0 is x, index 3 is w.
  typedef struct packed {
    op_t               op;
    logic [3:0][W-1:0] a;
    logic [3:0][W-1:0] b;
  } qau_entry_t;

  typedef struct packed {
    logic       valid;
    qau_entry_t e;
  } qau_head_t;

  // One multiplier step: operand indexes, target accumulator, sign and doubling.
  typedef struct packed {
    logic [1:0] pi;
    logic [1:0] qi;
    logic [1:0] acc;
    logic       neg;
    logic       dbl;
  } mop_t;

  function automatic logic signed [ACC_W-1:0] sx(input logic [W-1:0] v);
    return {{(ACC_W-W){v[W-1]}}, v};
  endfunction

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [W-1:0] r;
    if (v[ACC_W-1:W-1] == '0 || v[ACC_W-1:W-1] == '1) r = v[W-1:0];
    else if (v[ACC_W-1]) r = {1'b1, {(W-1){1'b0}}};
    else r = {1'b0, {(W-1){1'b1}}};
    return r;
  endfunction

  function automatic mop_t mk(input logic [1:0] p, input logic [1:0] q,
                              input logic [1:0] a, input logic n, input logic d);
    mop_t m;
    m.pi = p; m.qi = q; m.acc = a; m.neg = n; m.dbl = d;
    return m;
  endfunction

  function automatic logic [5:0] plen(input prog_t p);
    logic [5:0] r;
    unique case (p)
      PR_HAM:  r = 6'd16;
      PR_SQ:   r = 6'd4;
      default: r = 6'd8;
    endcase
    return r;
  endfunction

  // Micro-op table for the Hamilton product, squares and matrix rows.
  function automatic mop_t mop(input prog_t p, input logic [3:0] k);
    mop_t m;
    m = mk(2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
    unique case (p)
      PR_HAM: begin
        unique case (k)
          4'd0:  m = mk(2'd3, 2'd0, 2'd0, 1'b0, 1'b0);
          4'd1:  m = mk(2'd0, 2'd3, 2'd0, 1'b0, 1'b0);
          4'd2:  m = mk(2'd1, 2'd2, 2'd0, 1'b0, 1'b0);
          4'd3:  m = mk(2'd2, 2'd1, 2'd0, 1'b1, 1'b0);
          4'd4:  m = mk(2'd3, 2'd1, 2'd1, 1'b0, 1'b0);
          4'd5:  m = mk(2'd0, 2'd2, 2'd1, 1'b1, 1'b0);
          4'd6:  m = mk(2'd1, 2'd3, 2'd1, 1'b0, 1'b0);
          4'd7:  m = mk(2'd2, 2'd0, 2'd1, 1'b0, 1'b0);
          4'd8:  m = mk(2'd3, 2'd2, 2'd2, 1'b0, 1'b0);
          4'd9:  m = mk(2'd0, 2'd1, 2'd2, 1'b0, 1'b0);
          4'd10: m = mk(2'd1, 2'd0, 2'd2, 1'b1, 1'b0);
          4'd11: m = mk(2'd2, 2'd3, 2'd2, 1'b0, 1'b0);
          4'd12: m = mk(2'd3, 2'd3, 2'd3, 1'b0, 1'b0);
          4'd13: m = mk(2'd0, 2'd0, 2'd3, 1'b1, 1'b0);
          4'd14: m = mk(2'd1, 2'd1, 2'd3, 1'b1, 1'b0);
          default: m = mk(2'd2, 2'd2, 2'd3, 1'b1, 1'b0);
        endcase
      end
      PR_SQ: m = mk(k[1:0], k[1:0], 2'd0, 1'b0, 1'b0);
      PR_ROW0: begin
        unique case (k[2:0])
          3'd0: m = mk(2'd0, 2'd0, 2'd0, 1'b0, 1'b0);
          3'd1: m = mk(2'd1, 2'd1, 2'd0, 1'b1, 1'b0);
          3'd2: m = mk(2'd2, 2'd2, 2'd0, 1'b1, 1'b0);
          3'd3: m = mk(2'd3, 2'd3, 2'd0, 1'b0, 1'b0);
          3'd4: m = mk(2'd0, 2'd1, 2'd1, 1'b0, 1'b1);
          3'd5: m = mk(2'd2, 2'd3, 2'd1, 1'b0, 1'b1);
          3'd6: m = mk(2'd0, 2'd2, 2'd2, 1'b0, 1'b1);
          default: m = mk(2'd1, 2'd3, 2'd2, 1'b1, 1'b1);
        endcase
      end
      PR_ROW1: begin
        unique case (k[2:0])
          3'd0: m = mk(2'd0, 2'd1, 2'd0, 1'b0, 1'b1);
          3'd1: m = mk(2'd2, 2'd3, 2'd0, 1'b1, 1'b1);
          3'd2: m = mk(2'd3, 2'd3, 2'd1, 1'b0, 1'b0);
          3'd3: m = mk(2'd0, 2'd0, 2'd1, 1'b1, 1'b0);
          3'd4: m = mk(2'd1, 2'd1, 2'd1, 1'b0, 1'b0);
          3'd5: m = mk(2'd2, 2'd2, 2'd1, 1'b1, 1'b0);
          3'd6: m = mk(2'd1, 2'd2, 2'd2, 1'b0, 1'b1);
          default: m = mk(2'd0, 2'd3, 2'd2, 1'b0, 1'b1);
        endcase
      end
      default: begin
        unique case (k[2:0])
          3'd0: m = mk(2'd0, 2'd2, 2'd0, 1'b0, 1'b1);
          3'd1: m = mk(2'd1, 2'd3, 2'd0, 1'b0, 1'b1);
          3'd2: m = mk(2'd1, 2'd2, 2'd1, 1'b0, 1'b1);
          3'd3: m = mk(2'd0, 2'd3, 2'd1, 1'b1, 1'b1);
          3'd4: m = mk(2'd3, 2'd3, 2'd2, 1'b0, 1'b0);
          3'd5: m = mk(2'd0, 2'd0, 2'd2, 1'b1, 1'b0);
          3'd6: m = mk(2'd1, 2'd1, 2'd2, 1'b1, 1'b0);
          default: m = mk(2'd2, 2'd2, 2'd2, 1'b0, 1'b0);
        endcase
      end
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit: Q16.16 quaternion arithmetic unit
// Add, subtract, Hamilton product, divide, conjugate, norm, normalize,
// inverse, vector rotation and rotation matrix on signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low; the
//   operands struct carries the function code and quaternions a and b.
//   A two-entry queue sits between the front end and the execution unit, so
//   busy rises only when two transactions are waiting.
//   Each result appears on the result struct for one cycle with done high;
//   the receiver cannot stall, and last marks the final result of a
//   transaction. The matrix function yields four results, all others one.
//   Add, subtract, conjugate and unused codes are answered straight from the
//   queue head, one per cycle; the other functions run on the multiplier,
//   the square root and the divider.
//   The iterative divider (one quotient bit per cycle) and the two-bit square
//   root step serve the long operations; the shared 32x32 multiplier serves
//   product and matrix. Reset clears the queue and control; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qau_pkg::qau_in_t  operands,
  output logic              done,
  output qau_pkg::qau_out_t result
);

  qau_pkg::qau_head_t head;
  logic               pop;

  // Front end: acceptance, decode and queue.
  qau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .head     (head),
    .pop      (pop)
  );

  // Back end: arithmetic and result port.
  qau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result),
    .done   (done)
  );

endmodule

FILE: rtl/core/qau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_front: input acceptance, classification and two-entry queue
// Decodes the function code of each accepted transaction and holds it
// until the execution back end takes it.
// ----------------------------------------------------------------------------
module qau_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qau_pkg::qau_in_t  operands,
  output logic              busy,
  output qau_pkg::qau_head_t head,
  input  logic              pop
);

  qau_pkg::qau_entry_t mem [2];
  qau_pkg::qau_entry_t entry;
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  // Classify the function code and pack the operands.
  always_comb begin
    unique case (operands.func)
      qau_pkg::FN_ADD:  entry.op = qau_pkg::OP_ADD;
      qau_pkg::FN_SUB:  entry.op = qau_pkg::OP_SUB;
      qau_pkg::FN_PROD: entry.op = qau_pkg::OP_PROD;
      qau_pkg::FN_DIV:  entry.op = qau_pkg::OP_DIV;
      qau_pkg::FN_CONJ: entry.op = qau_pkg::OP_CONJ;
      qau_pkg::FN_NORM: entry.op = qau_pkg::OP_NORM;
      qau_pkg::FN_NRMZ: entry.op = qau_pkg::OP_NRMZ;
      qau_pkg::FN_INV:  entry.op = qau_pkg::OP_INV;
      qau_pkg::FN_ROT:  entry.op = qau_pkg::OP_ROT;
      qau_pkg::FN_MAT:  entry.op = qau_pkg::OP_MAT;
      default:          entry.op = qau_pkg::OP_NONE;
    endcase
    entry.a = {operands.a_w, operands.a_z, operands.a_y, operands.a_x};
    entry.b = {operands.b_w, operands.b_z, operands.b_y, operands.b_x};
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.e     = mem[rp];

endmodule

FILE: rtl/core/qau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div: radix-2 fixed-point divider
// Computes (num << FRAC_BITS) / den truncated toward zero, one quotient bit
// per cycle, and saturates the result to 32 bits. den must be nonzero.
// ----------------------------------------------------------------------------
module qau_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [qau_pkg::NUM_W-1:0] num,
  input  logic signed [qau_pkg::NUM_W-1:0] den,
  output logic                            done,
  output logic [qau_pkg::W-1:0]           quo
);

  localparam int DW = qau_pkg::DIV_DW;

  logic                      run;
  logic [5:0]                cnt;
  logic                      neg;
  logic [DW-1:0]             dvd;
  logic [DW-1:0]             q;
  logic [qau_pkg::NUM_W-1:0] dmag;
  logic [qau_pkg::NUM_W-1:0] rem;
  logic [qau_pkg::NUM_W:0]   r2;
  logic [qau_pkg::NUM_W-1:0] nmag;
  logic                      take;

  // Operand magnitudes and the trial subtraction.
  always_comb begin
    nmag = num[qau_pkg::NUM_W-1] ? qau_pkg::NUM_W'(-num) : qau_pkg::NUM_W'(num);
    r2   = {rem, dvd[DW-1]};
    take = (r2 >= {1'b0, dmag});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == 6'd1);
      if (start) begin
        run <= 1'b1;
        cnt <= 6'(DW);
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) run <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nmag, {qau_pkg::FRAC_BITS{1'b0}}};
      dmag <= den[qau_pkg::NUM_W-1] ? qau_pkg::NUM_W'(-den) : qau_pkg::NUM_W'(den);
      neg  <= num[qau_pkg::NUM_W-1] ^ den[qau_pkg::NUM_W-1];
      rem  <= '0;
      q    <= '0;
    end else if (run) begin
      rem <= take ? qau_pkg::NUM_W'(r2 - {1'b0, dmag}) : r2[qau_pkg::NUM_W-1:0];
      dvd <= {dvd[DW-2:0], 1'b0};
      q   <= {q[DW-2:0], take};
    end
  end

  // Sign and saturation of the final quotient.
  always_comb begin
    if (neg) begin
      if (q > DW'({1'b1, {(qau_pkg::W-1){1'b0}}})) quo = {1'b1, {(qau_pkg::W-1){1'b0}}};
      else quo = qau_pkg::W'(-q);
    end else begin
      if (q > DW'({1'b0, {(qau_pkg::W-1){1'b1}}})) quo = {1'b0, {(qau_pkg::W-1){1'b1}}};
      else quo = q[qau_pkg::W-1:0];
    end
  end

endmodule

FILE: rtl/core/qau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_back: execution back end of the quaternion arithmetic unit
// Runs one transaction at a time with a shared multiplier, a bit-pair square
// root and the iterative divider, and drives the registered result port.
// ----------------------------------------------------------------------------
module qau_back (
  input  logic               clk,
  input  logic               rst,
  input  qau_pkg::qau_head_t head,
  output logic               pop,
  output qau_pkg::qau_out_t  result,
  output logic               done
);

  localparam int W = qau_pkg::W;
  localparam int AW = qau_pkg::ACC_W;

  qau_pkg::state_t state, state_next;
  qau_pkg::op_t    op;
  qau_pkg::prog_t  prog, mul_prog;

  logic [3:0][W-1:0]  av, bv, pv, qv, res, pv_new, qv_new, sacc;
  logic [3:0][AW-1:0] acc;
  logic [5:0]  cnt;
  logic        pass;
  logic [1:0]  di;
  logic        dwait;
  logic [1:0]  st;

  logic signed [63:0] prod;
  logic        tv, tneg, tdbl, tsq;
  logic [1:0]  tacc;
  logic [65:0] ssum;
  logic [63:0] rad;
  logic [34:0] srem;
  logic [31:0] root;
  logic [34:0] sr2, trial;
  logic        carry;
  logic [32:0] nval;
  logic [W-1:0] nsat;

  logic        start_mul, load_pq, sqrt_init, emit, set_pass, advance, skip, mul_end;
  logic        div_start, div_done;
  logic signed [qau_pkg::NUM_W-1:0] div_num, div_den;
  logic [W-1:0] quo;
  qau_pkg::qau_out_t emit_val;
  qau_pkg::mop_t m;
  logic signed [AW-1:0] term;

  qau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  // Saturated accumulators, norm value and square-root trial.
  always_comb begin
    for (int i = 0; i < 4; i++) sacc[i] = qau_pkg::sat32(acc[i]);
    carry   = ssum[64] | ssum[65];
    nval    = carry ? {1'b1, 32'd0} : {1'b0, root};
    nsat    = (carry || root[31]) ? {1'b0, {(W-1){1'b1}}} : root;
    sr2     = {srem[32:0], rad[63:62]};
    trial   = {1'b0, root, 2'b01};
    mul_end = (cnt == qau_pkg::plen(prog) + 6'd1);
    m       = qau_pkg::mop(prog, cnt[3:0]);
    term    = AW'(prod >>> qau_pkg::FRAC_BITS);
    if (tdbl) term = term <<< 1;
    if (tneg) term = -term;
  end

  // Divider operand selection.
  always_comb begin
    div_den = $signed({1'b0, nval});
    unique case (op)
      qau_pkg::OP_DIV: begin
        div_num = 34'(qau_pkg::sx(av[di]));
        div_den = 34'(qau_pkg::sx(bv[di]));
      end
      qau_pkg::OP_INV: begin
        if (pass) div_num = 34'(qau_pkg::sx(res[di]));
        else if (di != 2'd3) div_num = -34'(qau_pkg::sx(av[di]));
        else div_num = 34'(qau_pkg::sx(av[di]));
      end
      default: div_num = 34'(qau_pkg::sx(av[di]));
    endcase
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start_mul  = 1'b0;
    mul_prog   = qau_pkg::PR_HAM;
    load_pq    = 1'b0;
    pv_new     = head.e.a;
    qv_new     = head.e.a;
    sqrt_init  = 1'b0;
    emit       = 1'b0;
    emit_val   = '0;
    set_pass   = 1'b0;
    advance    = 1'b0;
    skip       = 1'b0;
    div_start  = 1'b0;
    emit_val.status = qau_pkg::ST_OK;
    emit_val.last   = 1'b1;
    unique case (state)
      qau_pkg::S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          unique case (head.e.op)
            qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_CONJ, qau_pkg::OP_NONE: begin
              emit = 1'b1;
              if (head.e.op == qau_pkg::OP_ADD) begin
                emit_val.r_x = qau_pkg::sat32(qau_pkg::sx(head.e.a[0]) + qau_pkg::sx(head.e.b[0]));
                emit_val.r_y = qau_pkg::sat32(qau_pkg::sx(head.e.a[1]) + qau_pkg::sx(head.e.b[1]));
                emit_val.r_z = qau_pkg::sat32(qau_pkg::sx(head.e.a[2]) + qau_pkg::sx(head.e.b[2]));
                emit_val.r_w = qau_pkg::sat32(qau_pkg::sx(head.e.a[3]) + qau_pkg::sx(head.e.b[3]));
              end else if (head.e.op == qau_pkg::OP_SUB) begin
                emit_val.r_x = qau_pkg::sat32(qau_pkg::sx(head.e.a[0]) - qau_pkg::sx(head.e.b[0]));
                emit_val.r_y = qau_pkg::sat32(qau_pkg::sx(head.e.a[1]) - qau_pkg::sx(head.e.b[1]));
                emit_val.r_z = qau_pkg::sat32(qau_pkg::sx(head.e.a[2]) - qau_pkg::sx(head.e.b[2]));
                emit_val.r_w = qau_pkg::sat32(qau_pkg::sx(head.e.a[3]) - qau_pkg::sx(head.e.b[3]));
              end else if (head.e.op == qau_pkg::OP_CONJ) begin
                emit_val.r_x = qau_pkg::sat32(-qau_pkg::sx(head.e.a[0]));
                emit_val.r_y = qau_pkg::sat32(-qau_pkg::sx(head.e.a[1]));
                emit_val.r_z = qau_pkg::sat32(-qau_pkg::sx(head.e.a[2]));
                emit_val.r_w = head.e.a[3];
              end
            end
            qau_pkg::OP_PROD: begin
              load_pq    = 1'b1;
              qv_new     = head.e.b;
              start_mul  = 1'b1;
              state_next = qau_pkg::S_MUL;
            end
            qau_pkg::OP_DIV: state_next = qau_pkg::S_DIV;
            qau_pkg::OP_MAT: begin
              load_pq    = 1'b1;
              start_mul  = 1'b1;
              mul_prog   = qau_pkg::PR_ROW0;
              state_next = qau_pkg::S_MUL;
            end
            default: begin
              load_pq    = 1'b1;
              start_mul  = 1'b1;
              mul_prog   = qau_pkg::PR_SQ;
              state_next = qau_pkg::S_MUL;
            end
          endcase
        end
      end
      qau_pkg::S_MUL: begin
        if (mul_end) begin
          unique case (prog)
            qau_pkg::PR_SQ: begin
              sqrt_init  = 1'b1;
              state_next = qau_pkg::S_SQRT;
            end
            qau_pkg::PR_HAM: begin
              if (op == qau_pkg::OP_ROT && !pass) begin
                // Second product: t times the conjugate of q.
                load_pq   = 1'b1;
                pv_new    = sacc;
                for (int i = 0; i < 3; i++) qv_new[i] = qau_pkg::sat32(-qau_pkg::sx(pv[i]));
                qv_new[3] = pv[3];
                start_mul = 1'b1;
                set_pass  = 1'b1;
              end else begin
                emit         = 1'b1;
                emit_val.r_x = sacc[0];
                emit_val.r_y = sacc[1];
                emit_val.r_z = sacc[2];
                emit_val.r_w = (op == qau_pkg::OP_ROT) ? '0 : sacc[3];
                state_next   = qau_pkg::S_IDLE;
              end
            end
            default: begin
              emit          = 1'b1;
              emit_val.r_x  = sacc[0];
              emit_val.r_y  = sacc[1];
              emit_val.r_z  = sacc[2];
              emit_val.last = 1'b0;
              if (prog == qau_pkg::PR_ROW2) begin
                state_next = qau_pkg::S_ROW3;
              end else begin
                start_mul = 1'b1;
                mul_prog  = (prog == qau_pkg::PR_ROW0) ? qau_pkg::PR_ROW1 : qau_pkg::PR_ROW2;
              end
            end
          endcase
        end
      end
      qau_pkg::S_SQRT: begin
        if (cnt == 6'd32) begin
          if (op == qau_pkg::OP_NORM) begin
            emit         = 1'b1;
            emit_val.r_x = nsat;
            state_next   = qau_pkg::S_IDLE;
          end else if (ssum == '0) begin
            emit            = 1'b1;
            emit_val.status = qau_pkg::ST_ZERO;
            state_next      = qau_pkg::S_IDLE;
          end else begin
            state_next = qau_pkg::S_DIV;
          end
        end
      end
      qau_pkg::S_DIV: begin
        if (!dwait) begin
          if (op == qau_pkg::OP_DIV && bv[di] == '0) begin
            skip    = 1'b1;
            advance = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end else if (div_done) begin
          advance = 1'b1;
        end
        if (advance && di == 2'd3) state_next = qau_pkg::S_FIN;
      end
      qau_pkg::S_FIN: begin
        if (op == qau_pkg::OP_INV && !pass) begin
          set_pass   = 1'b1;
          state_next = qau_pkg::S_DIV;
        end else if (op == qau_pkg::OP_ROT) begin
          load_pq    = 1'b1;
          pv_new     = res;
          qv_new     = {32'd0, bv[2], bv[1], bv[0]};
          start_mul  = 1'b1;
          state_next = qau_pkg::S_MUL;
        end else begin
          emit            = 1'b1;
          emit_val.r_x    = res[0];
          emit_val.r_y    = res[1];
          emit_val.r_z    = res[2];
          emit_val.r_w    = res[3];
          emit_val.status = st;
          state_next      = qau_pkg::S_IDLE;
        end
      end
      qau_pkg::S_ROW3: begin
        emit         = 1'b1;
        emit_val.r_w = W'(1) << qau_pkg::FRAC_BITS;
        state_next   = qau_pkg::S_IDLE;
      end
      default: state_next = qau_pkg::S_IDLE;
    endcase
  end

  // State register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qau_pkg::S_IDLE;
      done  <= 1'b0;
      tv    <= 1'b0;
      dwait <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (start_mul) tv <= 1'b0;
      else if (state == qau_pkg::S_MUL) tv <= (cnt < qau_pkg::plen(prog));
      if (div_start) dwait <= 1'b1;
      else if (div_done) dwait <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (emit) result <= emit_val;
    if (pop) begin
      op   <= head.e.op;
      av   <= head.e.a;
      bv   <= head.e.b;
      pass <= 1'b0;
      di   <= 2'd0;
      st   <= qau_pkg::ST_OK;
    end
    if (load_pq) begin
      pv <= pv_new;
      qv <= qv_new;
    end
    if (set_pass) begin
      pass <= 1'b1;
      di   <= 2'd0;
    end
    // Multiplier issue and accumulation.
    if (start_mul) begin
      prog <= mul_prog;
      cnt  <= 6'd0;
      acc  <= '0;
      ssum <= '0;
    end else if (state == qau_pkg::S_MUL) begin
      cnt <= cnt + 6'd1;
      if (cnt < qau_pkg::plen(prog)) begin
        prod <= $signed(pv[m.pi]) * $signed(qv[m.qi]);
        tacc <= m.acc;
        tneg <= m.neg;
        tdbl <= m.dbl;
        tsq  <= (prog == qau_pkg::PR_SQ);
      end
      if (tv) begin
        if (tsq) ssum <= ssum + {2'b00, prod};
        else acc[tacc] <= acc[tacc] + term;
      end
    end
    // Square root, two radicand bits per cycle.
    if (sqrt_init) begin
      rad  <= ssum[63:0];
      srem <= '0;
      root <= '0;
      cnt  <= 6'd0;
    end else if (state == qau_pkg::S_SQRT && cnt != 6'd32) begin
      cnt <= cnt + 6'd1;
      rad <= {rad[61:0], 2'b00};
      if (sr2 >= trial) begin
        srem <= sr2 - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        srem <= sr2;
        root <= {root[30:0], 1'b0};
      end
    end
    // Divide results, one component at a time.
    if (advance) begin
      if (skip) begin
        res[di] <= av[di][W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        st      <= qau_pkg::ST_DIV0;
      end else begin
        res[di] <= quo;
      end
      di <= di + 2'd1;
    end
  end

`ifndef ASSERT_OFF
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("queue popped while empty");
  a_div_once: assert property (@(posedge clk) disable iff (rst) div_start |=> !div_start)
    else $error("divider restarted while running");
  a_row3: assert property (@(posedge clk) disable iff (rst)
    state == qau_pkg::S_ROW3 |=> done && result.last)
    else $error("matrix row 3 not delivered as the final result");
  a_mid_mat: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> op == qau_pkg::OP_MAT)
    else $error("non-final result outside a matrix transaction");
`endif

endmodule
